>>> hw/rtl/csim_pkg.sv
// Shared types and constants for the cosine similarity engine.
package csim_pkg;

  localparam int ElemWidth   = 16;
  localparam int MaxLength   = 4096;
  localparam int DotWidth    = 44;
  localparam int SqWidth     = 43;
  localparam int CountWidth  = 13;
  localparam int NormWidth   = 22;
  localparam int CosWidth    = 16;
  localparam int SqrtSteps   = 22;
  localparam int DivSteps    = 59;
  localparam int StepWidth   = 6;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_SQRT,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } csim_state_e;

  typedef struct packed {
    logic acc_en;
    logic sqrt_step;
    logic mul_en;
    logic div_step;
    logic out_load;
  } csim_cmd_t;

  typedef struct packed {
    logic out_busy;
  } csim_status_t;

endpackage

>>> hw/rtl/csim_in_if.sv
// Input channel: one element pair per word.
interface csim_in_if;
  import csim_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [ElemWidth-1:0] elem_a;
  logic signed [ElemWidth-1:0] elem_b;
  logic                        last;
  modport source (output valid, elem_a, elem_b, last, input ready);
  modport sink (input valid, elem_a, elem_b, last, output ready);
endinterface

>>> hw/rtl/csim_out_if.sv
// Output channel: one similarity result per word.
interface csim_out_if;
  import csim_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [CosWidth-1:0]  cosine;
  logic signed [DotWidth-1:0]  dot_value;
  logic        [NormWidth-1:0] norm_first;
  logic                        zero_norm;
  logic                        overflow;
  modport source (output valid, cosine, dot_value, norm_first, zero_norm, overflow,
                  input ready);
  modport sink (input valid, cosine, dot_value, norm_first, zero_norm, overflow,
                output ready);
endinterface

>>> hw/rtl/csim_ctrl.sv
// Controller state machine sequencing accumulate, root, multiply and divide.
module csim_ctrl import csim_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_last_i,
  output logic         in_ready_o,
  input  csim_status_t status_i,
  output csim_cmd_t    cmd_o
);

  csim_state_e           state_q, state_d;
  logic [StepWidth-1:0]  step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_ACC: begin
        in_ready_o   = 1'b1;
        cmd_o.acc_en = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_SQRT;
          step_d  = '0;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        step_d          = step_q + 1'b1;
        if (step_q == StepWidth'(SqrtSteps - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        step_d       = '0;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == StepWidth'(DivSteps - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

endmodule

>>> hw/rtl/csim_datapath.sv
// Datapath: accumulators, two square root units, norm product, divider, output register.
module csim_datapath import csim_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  csim_cmd_t                   cmd_i,
  output csim_status_t                status_o,
  input  logic signed [ElemWidth-1:0] elem_a_i,
  input  logic signed [ElemWidth-1:0] elem_b_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [CosWidth-1:0]  cosine_o,
  output logic signed [DotWidth-1:0]  dot_value_o,
  output logic        [NormWidth-1:0] norm_first_o,
  output logic                        zero_norm_o,
  output logic                        overflow_o
);

  localparam int RemW = NormWidth + 3;
  localparam int XW   = 2 * SqrtSteps;
  localparam int NumW = DivSteps;

  logic [DotWidth-1:0]   dot_acc_q;
  logic [SqWidth-1:0]    sq_a_acc_q, sq_b_acc_q;
  logic [CountWidth-1:0] count_q;
  logic                  ovf_acc_q;

  logic [DotWidth-1:0]   dot_w_q;
  logic                  ovf_w_q;
  logic [XW-1:0]         xa_q, xb_q;
  logic [RemW-1:0]       rema_q, remb_q;
  logic [NormWidth-1:0]  roota_q, rootb_q;
  logic [DotWidth-1:0]   den_q;
  logic [DotWidth:0]     drem_q;
  logic [NumW-1:0]       quo_q;

  logic                  out_valid_q;
  logic [CosWidth-1:0]   cos_q;
  logic [DotWidth-1:0]   dot_out_q;
  logic [NormWidth-1:0]  norm_q;
  logic                  zero_q, ovf_out_q;

  logic signed [2*ElemWidth-1:0] prod_ab, prod_aa, prod_bb;
  logic                  full;
  logic [DotWidth-1:0]   dot_nx;
  logic [SqWidth-1:0]    sqa_nx, sqb_nx;
  logic [DotWidth-1:0]   dot_mag;
  logic [DotWidth:0]     drem_sh;
  logic                  zero_n;
  logic [CosWidth-1:0]   cos_n;

  assign prod_ab = elem_a_i * elem_b_i;
  assign prod_aa = elem_a_i * elem_a_i;
  assign prod_bb = elem_b_i * elem_b_i;
  assign full    = {{(32-CountWidth){1'b0}}, count_q} >= 32'(MaxLength);
  assign dot_nx  = full ? dot_acc_q : dot_acc_q + DotWidth'(prod_ab);
  assign sqa_nx  = full ? sq_a_acc_q : sq_a_acc_q + SqWidth'($unsigned(prod_aa));
  assign sqb_nx  = full ? sq_b_acc_q : sq_b_acc_q + SqWidth'($unsigned(prod_bb));

  // Accumulate pairs; on the last pair move the totals into the work registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_acc_q  <= '0;
      sq_a_acc_q <= '0;
      sq_b_acc_q <= '0;
      count_q    <= '0;
      ovf_acc_q  <= 1'b0;
    end else if (cmd_i.acc_en) begin
      if (last_i) begin
        dot_acc_q  <= '0;
        sq_a_acc_q <= '0;
        sq_b_acc_q <= '0;
        count_q    <= '0;
        ovf_acc_q  <= 1'b0;
      end else begin
        dot_acc_q  <= dot_nx;
        sq_a_acc_q <= sqa_nx;
        sq_b_acc_q <= sqb_nx;
        count_q    <= full ? count_q : count_q + 1'b1;
        ovf_acc_q  <= ovf_acc_q | full;
      end
    end
  end

  function automatic logic [RemW+NormWidth+XW-1:0] sqrt_step(
      input logic [RemW-1:0] rem, input logic [NormWidth-1:0] root,
      input logic [XW-1:0] x);
    logic [RemW-1:0] r;
    logic [RemW-1:0] t;
    r = {rem[RemW-3:0], x[XW-1:XW-2]};
    t = {1'b0, root, 2'b01};
    if (r >= t) begin
      return {r - t, root[NormWidth-2:0], 1'b1, x[XW-3:0], 2'b00};
    end
    return {r, root[NormWidth-2:0], 1'b0, x[XW-3:0], 2'b00};
  endfunction

  assign dot_mag = dot_w_q[DotWidth-1] ? -dot_w_q : dot_w_q;
  assign drem_sh = {drem_q[DotWidth-1:0], quo_q[NumW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en && last_i) begin
      dot_w_q <= dot_nx;
      ovf_w_q <= ovf_acc_q | full;
      xa_q    <= {1'b0, sqa_nx};
      xb_q    <= {1'b0, sqb_nx};
      rema_q  <= '0;
      remb_q  <= '0;
      roota_q <= '0;
      rootb_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      {rema_q, roota_q, xa_q} <= sqrt_step(rema_q, roota_q, xa_q);
      {remb_q, rootb_q, xb_q} <= sqrt_step(remb_q, rootb_q, xb_q);
    end
    if (cmd_i.mul_en) begin
      den_q  <= DotWidth'(roota_q * rootb_q);
      drem_q <= '0;
      quo_q  <= {dot_mag, {(NumW-DotWidth){1'b0}}};
    end
    if (cmd_i.div_step) begin
      if (drem_sh >= {1'b0, den_q}) begin
        drem_q <= drem_sh - {1'b0, den_q};
        quo_q  <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        drem_q <= drem_sh;
        quo_q  <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign zero_n = (roota_q == '0) || (rootb_q == '0);

  // Apply sign and saturate to Q1.15.
  always_comb begin
    if (zero_n) begin
      cos_n = '0;
    end else if (dot_w_q[DotWidth-1]) begin
      cos_n = (quo_q > NumW'(32768)) ? 16'h8000 : CosWidth'(-quo_q);
    end else begin
      cos_n = (quo_q > NumW'(32767)) ? 16'h7fff : quo_q[CosWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      cos_q     <= cos_n;
      dot_out_q <= dot_w_q;
      norm_q    <= roota_q;
      zero_q    <= zero_n;
      ovf_out_q <= ovf_w_q;
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign cosine_o     = cos_q;
  assign dot_value_o  = dot_out_q;
  assign norm_first_o = norm_q;
  assign zero_norm_o  = zero_q;
  assign overflow_o   = ovf_out_q;

endmodule

>>> hw/rtl/cosine_similarity_engine_unit.sv
// Element pairs are accepted one per cycle; after the last pair the square root, multiply
//   and divide steps run, then the output register is loaded once it is free.
// A new vector pair is accepted only after the result is loaded; the divider's
//   bit-per-cycle loop sets the tail. Input is held off during the tail.
// Reset: rst_ni clears accumulators, state machine and output valid asynchronously.
module cosine_similarity_engine_unit import csim_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  csim_in_if.sink   in_i,
  csim_out_if.source out_o
);

  csim_cmd_t    cmd;
  csim_status_t status;

  // Sequence accept, root, multiply, divide and result load.
  csim_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold the sums, the iterative units and the output word.
  csim_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .elem_a_i     (in_i.elem_a),
    .elem_b_i     (in_i.elem_b),
    .last_i       (in_i.last),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .cosine_o     (out_o.cosine),
    .dot_value_o  (out_o.dot_value),
    .norm_first_o (out_o.norm_first),
    .zero_norm_o  (out_o.zero_norm),
    .overflow_o   (out_o.overflow)
  );

endmodule

>>> hw/rtl/csim_checker.sv
// Port-level checks for the cosine similarity engine, bound to the top level.
module csim_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] cosine_i,
  input logic [43:0] dot_value_i,
  input logic        zero_norm_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input accepted during result computation");

  a_zero_cos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zero_norm_i |-> cosine_i == 16'h0000)
    else $error("nonzero cosine with zero norm");

  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && dot_value_i[43] |-> cosine_i[15] || cosine_i == 16'h0000)
    else $error("cosine sign disagrees with dot product");

endmodule

bind cosine_similarity_engine_unit csim_checker u_csim_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .cosine_i    (out_o.cosine),
  .dot_value_i (out_o.dot_value),
  .zero_norm_i (out_o.zero_norm)
);
